@@ src/bitmap_frame_allocator_unit_macros.svh @@
// Assertion shorthands shared by the checker files.
// Every assertion is clocked on clock; the first form is muted during reset.
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// check a property outside reset
`define BFA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property at every edge, reset included
`define BFA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/bfa_pkg.sv @@
`default_nettype none

package bfa_pkg;

   localparam int MAX_FRAMES  = 4096;
   localparam int WORD_BITS   = 32;
   localparam int FRAME_SPACE = 4096;
   localparam int FRAME_W     = 12;
   localparam int KIND_W      = 2;
   localparam int STAT_W      = 2;
   localparam int COUNT_W     = 13;
   localparam int COUNT_RESET = 4096;

   localparam int NWORDS    = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int WADDR_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int SPAN_W    = ((COUNT_W > WADDR_W + BIT_W) ? COUNT_W : WADDR_W + BIT_W) + 1;
   localparam int LIMIT_CAP = (MAX_FRAMES < FRAME_SPACE) ? MAX_FRAMES : FRAME_SPACE;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_TEST  = 2'd2
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE    = 2'd0,
      STAT_NOTHING = 2'd1,
      STAT_NO_FREE = 2'd2
   } stat_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DISPATCH,
      FSM_SCAN,
      FSM_FREE,
      FSM_TEST,
      FSM_DONE
   } fsm_state_type;

   typedef struct packed {
      logic                 rd_en;
      logic [WADDR_W-1:0]   rd_addr;
      logic                 wr_en;
      logic [WADDR_W-1:0]   wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } ram_req_type;

   typedef struct packed {
      logic [FRAME_W-1:0] result_frame;
      logic               present;
      logic               writeable;
      logic               user_mode;
      stat_type           status;
      logic               used;
   } result_type;

endpackage

`default_nettype wire

@@ src/bfa_if.sv @@
`default_nettype none

interface bfa_req_if import bfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [FRAME_W-1:0] frame;
   logic               is_kernel;
   logic               is_writeable;

   modport source (output valid, kind, frame, is_kernel, is_writeable, input ready);
   modport sink   (input valid, kind, frame, is_kernel, is_writeable, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FRAME_W-1:0] result_frame;
   logic               present;
   logic               writeable;
   logic               user_mode;
   logic [STAT_W-1:0]  status;
   logic               used;

   modport source (output valid, result_frame, present, writeable, user_mode, status, used,
                   input ready);
   modport sink   (input valid, result_frame, present, writeable, user_mode, status, used,
                   output ready);
endinterface

interface bfa_csr_if import bfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ src/bitmap_frame_allocator_unit.sv @@
// Channel   Dir  Handshake     Word
// req_bus   in   valid/ready   kind, frame, is_kernel, is_writeable
// rsp_bus   out  valid/ready   result_frame, present, writeable, user_mode, status, used
// csr_bus   in   valid/ready   frame_count (always ready)
//
// Allocate with frame zero reads bitmap words in turn (1 to 128 of them), one word
// per cycle from the bitmap RAM. Free reads the word, then modifies and writes it
// back; test reads the word only. Reset clears a per-word valid flag at once, so
// the bitmap reads all free with no clearing pass. A new request is taken while
// the previous word still waits in the response register; a stalled response
// holds the engine in its last state.

`default_nettype none

module bitmap_frame_allocator_unit import bfa_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   bfa_req_if.sink   req_bus,
   bfa_rsp_if.source rsp_bus,
   bfa_csr_if.sink   csr_bus
);

   logic [COUNT_W-1:0]   frame_count_ff, frame_count_in;
   ram_req_type          ram_req;
   logic [WORD_BITS-1:0] rd_word;
   result_type           result;
   logic                 result_valid;
   logic                 out_ready;

   // frame count register; the user must write it only while idle, the block does not enforce this
   assign csr_bus.ready  = 1'b1;
   assign frame_count_in = csr_bus.data;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= COUNT_W'(COUNT_RESET);
      end else if (csr_bus.valid) begin
         frame_count_ff <= frame_count_in;
      end
   end

   // bitmap store: one read and one write port, registered read data
   bfa_bitmap_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_word (rd_word)
   );

   // sequencer: dispatch, word-by-word scan, read-modify-write of the bitmap.
   // Requests are serialized, so a write-back always lands before the next read.
   bfa_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .frame_count  (frame_count_ff),
      .ram_req      (ram_req),
      .rd_word      (rd_word),
      .result       (result),
      .result_valid (result_valid),
      .out_ready    (out_ready)
   );

   // response register decouples the engine from a stalled consumer
   bfa_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load_valid (result_valid),
      .load_data  (result),
      .load_ready (out_ready),
      .rsp        (rsp_bus)
   );

endmodule

`default_nettype wire

@@ src/bfa_bitmap_ram.sv @@
`default_nettype none

module bfa_bitmap_ram import bfa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ram_req_type          ram_req,
   output logic      [WORD_BITS-1:0] rd_word
);

   logic [WORD_BITS-1:0] bitmap_mem [NWORDS];
   logic [NWORDS-1:0]    valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;

   // storage array, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         bitmap_mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= bitmap_mem[ram_req.rd_addr];
      end
   end

   // a word never written reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ram_req.wr_en) begin
            valid_ff[ram_req.wr_addr] <= 1'b1;
         end
         if (ram_req.rd_en) begin
            rd_valid_ff <= valid_ff[ram_req.rd_addr];
         end
      end
   end

   assign rd_word = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

@@ src/bfa_engine.sv @@
`default_nettype none

module bfa_engine import bfa_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   bfa_req_if.sink                 req,
   input  wire logic [COUNT_W-1:0] frame_count,
   output ram_req_type             ram_req,
   input  wire logic [WORD_BITS-1:0] rd_word,
   output result_type              result,
   output logic                    result_valid,
   input  wire logic               out_ready
);

   fsm_state_type        state_ff, state_in;
   kind_type             kind_ff;
   logic [FRAME_W-1:0]   frame_ff;
   logic                 kernel_ff;
   logic                 wflag_ff;
   logic [COUNT_W-1:0]   limit_ff, limit_in;
   logic [WADDR_W-1:0]   word_ff, word_in;
   result_type           result_ff, result_in;

   logic                 req_ready;
   logic                 accept;
   logic [SPAN_W-1:0]    base;
   logic [SPAN_W-1:0]    rem;
   logic [WORD_BITS-1:0] limit_mask;
   logic [WORD_BITS-1:0] free_bits;
   logic                 found;
   logic                 last_word;
   logic [BIT_W-1:0]     free_idx;
   logic                 in_range;
   logic [WADDR_W-1:0]   frame_word;
   logic [WORD_BITS-1:0] frame_onehot;

   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) idx = BIT_W'(i);
      end
      return idx;
   endfunction

   assign accept    = req.valid && req_ready;
   assign req.ready = req_ready;

   assign limit_in = (frame_count > COUNT_W'(LIMIT_CAP)) ? COUNT_W'(LIMIT_CAP) : frame_count;

   // scan datapath for the word under examination
   assign base       = SPAN_W'({word_ff, {BIT_W{1'b0}}});
   assign rem        = SPAN_W'(limit_ff) - base;
   assign limit_mask = (rem >= SPAN_W'(WORD_BITS)) ? '1 :
                       ((WORD_BITS'(1) << rem[BIT_W-1:0]) - WORD_BITS'(1));
   assign free_bits  = ~rd_word & limit_mask;
   assign found      = |free_bits;
   assign free_idx   = lowest_set(free_bits);
   assign last_word  = (base + SPAN_W'(WORD_BITS) >= SPAN_W'(limit_ff)) ||
                       (word_ff == WADDR_W'(NWORDS - 1));

   // addressing of a named frame
   assign in_range     = SPAN_W'(frame_ff) < SPAN_W'(MAX_FRAMES);
   assign frame_word   = WADDR_W'(frame_ff >> BIT_W);
   assign frame_onehot = WORD_BITS'(1) << frame_ff[BIT_W-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req.valid) state_in = FSM_DISPATCH;
         end
         FSM_DISPATCH: begin
            case (kind_ff)
               KIND_ALLOC: begin
                  state_in = (frame_ff != '0 || limit_ff == '0) ? FSM_DONE : FSM_SCAN;
               end
               KIND_FREE: begin
                  state_in = (frame_ff != '0 && in_range) ? FSM_FREE : FSM_DONE;
               end
               KIND_TEST: begin
                  state_in = in_range ? FSM_TEST : FSM_DONE;
               end
               default: begin
                  state_in = FSM_DONE;
               end
            endcase
         end
         FSM_SCAN: begin
            if (found || last_word) state_in = FSM_DONE;
         end
         FSM_FREE, FSM_TEST: begin
            state_in = FSM_DONE;
         end
         FSM_DONE: begin
            if (out_ready) state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ram_req   = '0;
      word_in   = word_ff;
      result_in = result_ff;
      case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
         end
         FSM_DISPATCH: begin
            result_in        = '0;
            result_in.status = STAT_NOTHING;
            case (kind_ff)
               KIND_ALLOC: begin
                  if (frame_ff != '0) begin
                     result_in.result_frame = frame_ff;
                  end else if (limit_ff == '0) begin
                     result_in.status = STAT_NO_FREE;
                  end else begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = '0;
                     word_in         = '0;
                  end
               end
               KIND_FREE: begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = frame_word;
               end
               KIND_TEST: begin
                  // out-of-range frames test as free
                  result_in.result_frame = frame_ff;
                  result_in.status       = STAT_DONE;
                  ram_req.rd_en          = 1'b1;
                  ram_req.rd_addr        = frame_word;
               end
               default: begin
                  result_in.status = STAT_NOTHING;
               end
            endcase
         end
         FSM_SCAN: begin
            if (found) begin
               ram_req.wr_en          = 1'b1;
               ram_req.wr_addr        = word_ff;
               ram_req.wr_data        = rd_word | (WORD_BITS'(1) << free_idx);
               result_in.result_frame = FRAME_W'(base + SPAN_W'(free_idx));
               result_in.present      = 1'b1;
               result_in.writeable    = wflag_ff;
               result_in.user_mode    = ~kernel_ff;
               result_in.status       = STAT_DONE;
            end else if (last_word) begin
               result_in.status = STAT_NO_FREE;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = word_ff + WADDR_W'(1);
               word_in         = word_ff + WADDR_W'(1);
            end
         end
         FSM_FREE: begin
            ram_req.wr_en    = 1'b1;
            ram_req.wr_addr  = frame_word;
            ram_req.wr_data  = rd_word & ~frame_onehot;
            result_in.status = STAT_DONE;
         end
         FSM_TEST: begin
            result_in.used = |(rd_word & frame_onehot);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind_type'(req.kind);
         frame_ff  <= req.frame;
         kernel_ff <= req.is_kernel;
         wflag_ff  <= req.is_writeable;
         limit_ff  <= limit_in;
      end
      word_ff   <= word_in;
      result_ff <= result_in;
   end

   assign result       = result_ff;
   assign result_valid = (state_ff == FSM_DONE);

endmodule

`default_nettype wire

@@ src/bfa_rsp_reg.sv @@
`default_nettype none

module bfa_rsp_reg import bfa_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load_valid,
   input  wire result_type load_data,
   output logic            load_ready,
   bfa_rsp_if.source       rsp
);

   logic       valid_ff;
   result_type data_ff;

   // take a new word when empty or when the held one leaves this cycle
   assign load_ready = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_valid && load_ready) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         data_ff <= load_data;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.result_frame = data_ff.result_frame;
   assign rsp.present      = data_ff.present;
   assign rsp.writeable    = data_ff.writeable;
   assign rsp.user_mode    = data_ff.user_mode;
   assign rsp.status       = data_ff.status;
   assign rsp.used         = data_ff.used;

endmodule

`default_nettype wire

@@ src/bfa_checker.sv @@
`default_nettype none

`include "bitmap_frame_allocator_unit_macros.svh"

module bfa_checker import bfa_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [FRAME_W-1:0] rsp_result_frame,
   input wire logic               rsp_present,
   input wire logic [STAT_W-1:0]  rsp_status,
   input wire logic               rsp_used
);

   logic [1:0] pending_ff, pending_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) pending_in = pending_ff + 2'd1;
      if (!req_take && rsp_take) pending_in = pending_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `BFA_ASSERT(rsp_hold_a, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_frame) && $stable(rsp_status), "response changed while stalled")
   `BFA_ASSERT(rsp_owed_a, rsp_valid |-> pending_ff != 2'd0, "response with no request outstanding")
   `BFA_ASSERT(full_stall_a, pending_ff == 2'd2 |-> !req_ready, "request taken with two outstanding")
   `BFA_ASSERT(present_done_a, rsp_valid && rsp_present |-> rsp_status == STAT_DONE && !rsp_used, "new frame with bad status")
   `BFA_ASSERT_ALWAYS(reset_quiet_a, $past(reset) |-> !rsp_valid, "response right after reset")

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_result_frame (rsp_bus.result_frame),
   .rsp_present      (rsp_bus.present),
   .rsp_status       (rsp_bus.status),
   .rsp_used         (rsp_bus.used)
);

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import bfa_pkg::*;

   // Kind code the block must treat as a no-op.
   localparam logic [KIND_W-1:0] KIND_BOGUS = 2'd3;
   localparam logic N = 1'b0;
   localparam logic Y = 1'b1;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned DRAIN_CYCLES = 140;
   localparam int unsigned WORDS_PER_PHASE = 55;
   localparam int unsigned LONG_HOLD = 400;
   localparam result_type IDLE_WORD = '{12'd0, N, N, N, STAT_NOTHING, N};

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FRAME_W-1:0] frame;
      logic               is_kernel;
      logic               is_writeable;
   } page_request;

   // One line of the directed script: either a frame_count write or a request,
   // with the answer spelled out where it is obvious by inspection.
   typedef struct packed {
      logic               is_cfg;
      logic [COUNT_W-1:0] count;
      logic [KIND_W-1:0]  kind;
      logic [FRAME_W-1:0] frame;
      logic               is_kernel;
      logic               is_writeable;
      logic               typed;
      result_type         want;
   } script_row;

   logic clock;
   logic reset;

   bfa_req_if req_bus ();
   bfa_rsp_if rsp_bus ();
   bfa_csr_if csr_bus ();

   bitmap_frame_allocator_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow of the block: used-frame bitmap and the programmed frame count.
   logic [WORD_BITS-1:0] frame_map [NWORDS];
   logic [COUNT_W-1:0]   granted_frames;

   result_type  pending_outcomes [$];
   result_type  oldest;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   bit          no_idle = 1'b0;
   int unsigned long_hold_cycles = 0;

   // Directed script, run at the reset frame count of 4096 until the first write.
   script_row script [25] = '{
      // test after reset: everything free
      '{N, 13'd0, KIND_TEST,  12'd0,    N, N, Y, '{12'd0,    N, N, N, STAT_DONE,    N}},
      // frame zero is the first one handed out
      '{N, 13'd0, KIND_ALLOC, 12'd0,    N, Y, Y, '{12'd0,    Y, Y, Y, STAT_DONE,    N}},
      '{N, 13'd0, KIND_ALLOC, 12'd0,    Y, N, Y, '{12'd1,    Y, N, N, STAT_DONE,    N}},
      // page already holds a frame
      '{N, 13'd0, KIND_ALLOC, 12'd4095, Y, Y, Y, '{12'd4095, N, N, N, STAT_NOTHING, N}},
      '{N, 13'd0, KIND_TEST,  12'd1,    N, N, Y, '{12'd1,    N, N, N, STAT_DONE,    Y}},
      '{N, 13'd0, KIND_TEST,  12'd4095, Y, Y, Y, '{12'd4095, N, N, N, STAT_DONE,    N}},
      // free of frame zero does nothing
      '{N, 13'd0, KIND_FREE,  12'd0,    N, N, Y, '{12'd0,    N, N, N, STAT_NOTHING, N}},
      '{N, 13'd0, KIND_FREE,  12'd1,    N, N, Y, '{12'd0,    N, N, N, STAT_DONE,    N}},
      // free of a frame that is already free
      '{N, 13'd0, KIND_FREE,  12'd1,    Y, Y, Y, '{12'd0,    N, N, N, STAT_DONE,    N}},
      '{N, 13'd0, KIND_TEST,  12'd1,    N, N, Y, '{12'd1,    N, N, N, STAT_DONE,    N}},
      // unknown kind
      '{N, 13'd0, KIND_BOGUS, 12'd4095, Y, Y, Y, IDLE_WORD},
      '{N, 13'd0, KIND_FREE,  12'd4095, N, N, Y, '{12'd0,    N, N, N, STAT_DONE,    N}},
      // freed frame one comes back first
      '{N, 13'd0, KIND_ALLOC, 12'd0,    N, N, Y, '{12'd1,    Y, N, Y, STAT_DONE,    N}},
      '{N, 13'd0, KIND_ALLOC, 12'd0,    Y, Y, N, IDLE_WORD},
      '{N, 13'd0, KIND_TEST,  12'hAAA,  N, Y, N, IDLE_WORD},
      '{N, 13'd0, KIND_TEST,  12'h555,  Y, N, N, IDLE_WORD},
      // a single frame, already used: bitmap full
      '{Y, 13'd1, KIND_ALLOC, 12'd0,    N, N, N, IDLE_WORD},
      '{N, 13'd0, KIND_ALLOC, 12'd0,    N, Y, Y, '{12'd0,    N, N, N, STAT_NO_FREE, N}},
      '{N, 13'd0, KIND_TEST,  12'd2,    N, N, N, IDLE_WORD},
      // a count of zero leaves nothing to hand out
      '{Y, 13'd0, KIND_ALLOC, 12'd0,    N, N, N, IDLE_WORD},
      '{N, 13'd0, KIND_ALLOC, 12'd0,    Y, N, Y, '{12'd0,    N, N, N, STAT_NO_FREE, N}},
      // oversized count clips to the bitmap
      '{Y, 13'd8191, KIND_ALLOC, 12'd0, N, N, N, IDLE_WORD},
      '{N, 13'd0, KIND_ALLOC, 12'd0,    N, Y, N, IDLE_WORD},
      '{N, 13'd0, KIND_BOGUS, 12'd0,    N, N, Y, IDLE_WORD},
      '{N, 13'd0, KIND_ALLOC, 12'd1,    N, N, Y, '{12'd1,    N, N, N, STAT_NOTHING, N}}
   };

   // Frame counts of the random phases; the bitmap carries over between them.
   int unsigned phase_counts [10] = '{32, 1, 64, 0, 100, 8191, 40, 4096, 200, 33};

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Scan limit of an allocation: the count, clipped to what the bitmap holds.
   function automatic int unsigned frame_limit();
      return (granted_frames > LIMIT_CAP) ? LIMIT_CAP : granted_frames;
   endfunction

   // Work out the answer to one request and advance the shadow bitmap.
   function automatic result_type frame_outcome(input page_request word);
      result_type  r;
      int          hit;
      int unsigned limit;
      r = IDLE_WORD;
      case (word.kind)
         KIND_ALLOC: begin
            if (word.frame != '0) begin
               r.result_frame = word.frame;
            end else begin
               limit = frame_limit();
               hit = -1;
               for (int f = 0; f < limit && hit < 0; f++) begin
                  if (!frame_map[f / WORD_BITS][f % WORD_BITS]) hit = f;
               end
               if (hit < 0) begin
                  r.status = STAT_NO_FREE;
               end else begin
                  frame_map[hit / WORD_BITS][hit % WORD_BITS] = 1'b1;
                  r.result_frame = FRAME_W'(hit);
                  r.present      = 1'b1;
                  r.writeable    = word.is_writeable;
                  r.user_mode    = ~word.is_kernel;
                  r.status       = STAT_DONE;
               end
            end
         end
         KIND_FREE: begin
            if (word.frame != '0 && word.frame < MAX_FRAMES) begin
               frame_map[word.frame / WORD_BITS][word.frame % WORD_BITS] = 1'b0;
               r.status = STAT_DONE;
            end
         end
         KIND_TEST: begin
            r.result_frame = word.frame;
            if (word.frame < MAX_FRAMES)
               r.used = frame_map[word.frame / WORD_BITS][word.frame % WORD_BITS];
            r.status = STAT_DONE;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Random request: frames mostly near the scan window so frees and tests
   // land on frames that allocation actually hands out.
   function automatic page_request random_word();
      page_request word;
      int unsigned roll;
      int unsigned reach;
      reach = frame_limit() + 8;
      if (reach > MAX_FRAMES) reach = MAX_FRAMES;
      roll = $urandom_range(0, 99);
      word.is_kernel    = 1'($urandom_range(0, 1));
      word.is_writeable = 1'($urandom_range(0, 1));
      word.frame = ($urandom_range(0, 9) < 7) ? FRAME_W'($urandom_range(0, reach - 1))
                                                : FRAME_W'($urandom);
      if (roll < 45) begin
         word.kind = KIND_ALLOC;
         // mostly pages without a frame; a few that already hold one
         if ($urandom_range(0, 9) != 0) word.frame = '0;
      end else if (roll < 75) begin
         word.kind = KIND_FREE;
      end else if (roll < 95) begin
         word.kind = KIND_TEST;
      end else begin
         word.kind = KIND_BOGUS;
      end
      return word;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      // cap the log; every mismatch still counts
      if (mismatches < 200)
         $display("mismatch %s: got %0d, want %0d (cycle %0d)", field, got, want, cycle_count);
      mismatches++;
   endtask

   // Offer one word after a random gap, hold it until taken, then record the answer.
   task automatic send_word(input page_request word, input logic typed,
                            input result_type want);
      int unsigned gap;
      result_type  outcome;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= word.kind;
      req_bus.frame        <= word.frame;
      req_bus.is_kernel    <= word.is_kernel;
      req_bus.is_writeable <= word.is_writeable;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      outcome = frame_outcome(word);
      pending_outcomes.push_back(typed ? want : outcome);
   endtask

   // Drop the request, drain every answer, then write frame_count.
   task automatic write_frame_count(input logic [COUNT_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      granted_frames = value;
   endtask

   // Sender: directed script, then random phases at a range of frame counts.
   initial begin : stimulus
      page_request word;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.kind         <= KIND_ALLOC;
      req_bus.frame        <= '0;
      req_bus.is_kernel    <= 1'b0;
      req_bus.is_writeable <= 1'b0;
      csr_bus.valid        <= 1'b0;
      csr_bus.data         <= '0;
      foreach (frame_map[w]) frame_map[w] = '0;
      granted_frames = COUNT_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].is_cfg) begin
            write_frame_count(script[i].count);
         end else begin
            word = '{script[i].kind, script[i].frame, script[i].is_kernel,
                     script[i].is_writeable};
            send_word(word, script[i].typed, script[i].want);
         end
      end

      foreach (phase_counts[p]) begin
         write_frame_count(COUNT_W'(phase_counts[p]));
         // some phases run back to back on both sides
         no_idle = (p % 3 == 1);
         if (p == 2) begin
            // stall the answers for a long stretch while requests keep coming
            no_idle = 1'b1;
            long_hold_cycles = LONG_HOLD;
         end
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            word = random_word();
            send_word(word, 1'b0, IDLE_WORD);
         end
      end

      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      // let any stray answer show up before closing
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Receiver: random stall before each word, plus one long hold-off on request.
   initial begin : sink_side
      int unsigned pause;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (long_hold_cycles != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (long_hold_cycles) @(posedge clock);
            long_hold_cycles = 0;
         end
         pause = no_idle ? 0 : $urandom_range(0, 17);
         if (pause != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
      end
   end

   // Compare each accepted answer with the oldest one waiting.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("word with nothing waiting", rsp_bus.result_frame, -1);
         end else begin
            oldest = pending_outcomes.pop_front();
            if (rsp_bus.result_frame !== oldest.result_frame)
               report_mismatch("result_frame", rsp_bus.result_frame, oldest.result_frame);
            if (rsp_bus.present !== oldest.present)
               report_mismatch("present", rsp_bus.present, oldest.present);
            if (rsp_bus.writeable !== oldest.writeable)
               report_mismatch("writeable", rsp_bus.writeable, oldest.writeable);
            if (rsp_bus.user_mode !== oldest.user_mode)
               report_mismatch("user_mode", rsp_bus.user_mode, oldest.user_mode);
            if (rsp_bus.status !== oldest.status)
               report_mismatch("status", rsp_bus.status, oldest.status);
            if (rsp_bus.used !== oldest.used)
               report_mismatch("used", rsp_bus.used, oldest.used);
         end
      end
   end

   // Watchdog: abandon a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
